FILE: rtl/assert_macros.svh
// assertion macros used by the conditioner top level
// no dependencies; compiled away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: rtl/jac_pkg.sv
// shared types and constants of the joystick axis conditioner
// no dependencies
package jac_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int FS_W       = 7;
  localparam int DIR_W      = 8;
  localparam int PROD_W     = SAMPLE_W + FS_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 2;

  localparam int SAMPLES_PER_READ_DEF = 4;
  localparam int ADC_MAX_DEF          = 4095;
  localparam int QUEUE_DEPTH          = 2;

  localparam logic [SAMPLE_W-1:0] CENTER_RST    = 12'd2047;
  localparam logic [SAMPLE_W-1:0] DEAD_ZONE_RST = 12'd300;
  localparam logic [FS_W-1:0]     FULL_SCALE_RST = 7'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X   = 2'd0,
    CFG_CENTER_Y   = 2'd1,
    CFG_DEAD_ZONE  = 2'd2,
    CFG_FULL_SCALE = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] center_x;
    logic [SAMPLE_W-1:0] center_y;
    logic [SAMPLE_W-1:0] dead_zone;
    logic [FS_W-1:0]     full_scale;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PREP,
    BK_SCALE,
    BK_FIN
  } bk_state_t;

endpackage

FILE: rtl/jac_fifo.sv
// short job queue between the front and back parts
// depends on jac_pkg
module jac_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = jac_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [WIDTH-1:0]    wdata,
  input  logic                pop,
  output logic [WIDTH-1:0]    rdata,
  output jac_pkg::q_status_t  status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata        = mem_r[rd_ptr_r];
  assign status.full  = (cnt_r == CW'(DEPTH));
  assign status.empty = (cnt_r == '0);

endmodule

FILE: rtl/jac_front.sv
// front part: takes samples, sums them per read, posts finished reads and failed samples as jobs
// depends on jac_pkg
module jac_front #(
  parameter int SAMPLES_PER_READ = jac_pkg::SAMPLES_PER_READ_DEF,
  parameter int SUM_W            = jac_pkg::SAMPLE_W + $clog2(SAMPLES_PER_READ)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [jac_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                         in_axis,
  input  logic                         in_sample_ok,
  input  jac_pkg::q_status_t           q_status,
  output logic                         q_push,
  output logic [SUM_W+1:0]             q_wdata
);

  localparam int CNT_W = (SAMPLES_PER_READ > 1) ? $clog2(SAMPLES_PER_READ) : 1;

  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] job_sum;
  logic             accept;
  logic             last;

  assign in_tready = !q_status.full;
  assign accept    = in_tvalid && in_tready;
  assign last      = (cnt_r == CNT_W'(SAMPLES_PER_READ - 1));
  assign job_sum   = sum_r + SUM_W'(in_sample);

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    q_push  = 1'b0;
    if (accept) begin
      if (!in_sample_ok || last) begin
        sum_nxt = '0;
        cnt_nxt = '0;
        q_push  = 1'b1;
      end else begin
        sum_nxt = job_sum;
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  assign q_wdata = {in_sample_ok, in_axis, in_sample_ok ? job_sum : {SUM_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/jac_div.sv
// restoring divider, one quotient bit per cycle
// depends on nothing but its parameters
module jac_div #(
  parameter int DVD_W = 19,
  parameter int DVS_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   trial;
  logic             ge;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/jac_back.sv
// back part: averages a read, applies center, dead zone and scaling, holds the result
// depends on jac_pkg and jac_div
module jac_back #(
  parameter int SAMPLES_PER_READ = jac_pkg::SAMPLES_PER_READ_DEF,
  parameter int ADC_MAX          = jac_pkg::ADC_MAX_DEF,
  parameter int SUM_W            = jac_pkg::SAMPLE_W + $clog2(SAMPLES_PER_READ)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  jac_pkg::cfg_t                cfg,
  input  jac_pkg::q_status_t           q_status,
  output logic                         q_pop,
  input  logic [SUM_W+1:0]             q_rdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic                         out_axis,
  output logic [jac_pkg::SAMPLE_W-1:0] out_raw,
  output logic [jac_pkg::DIR_W-1:0]    out_dir,
  output logic                         out_ok
);

  localparam int SW     = jac_pkg::SAMPLE_W;
  localparam int SPAN_W = $clog2(ADC_MAX + 1);
  localparam int CMP_W  = (SPAN_W > SW) ? SPAN_W : SW;
  localparam int DIV_W  = jac_pkg::PROD_W;
  // average by reciprocal multiply, exact for every sum that fits SUM_W
  localparam int RCP_SH = SUM_W + $clog2(SAMPLES_PER_READ);
  localparam int RCP_W  = SUM_W + 2;
  localparam int AVP_W  = SUM_W + RCP_W;
  localparam int RCP_M  = ((1 << RCP_SH) + SAMPLES_PER_READ - 1) / SAMPLES_PER_READ;

  jac_pkg::bk_state_t state_r, state_nxt;

  logic                       axis_r, axis_nxt;
  logic [SW-1:0]              avg_r, avg_nxt;
  logic [jac_pkg::DIR_W-1:0]  dir_r, dir_nxt;
  logic                       ok_r, ok_nxt;
  logic                       neg_r, neg_nxt;
  logic                       ov_r, ov_nxt;
  logic                       load_out;

  logic                       out_axis_r;
  logic [SW-1:0]              out_raw_r;
  logic [jac_pkg::DIR_W-1:0]  out_dir_r;
  logic                       out_ok_r;

  logic                       job_ok;
  logic                       job_axis;
  logic [SUM_W-1:0]           job_sum;
  logic [AVP_W-1:0]           avg_prod;
  logic [SW-1:0]              job_avg;

  logic                       div_start;
  logic [DIV_W-1:0]           div_dvd;
  logic [CMP_W-1:0]           div_dvs;
  logic                       div_done;
  logic [DIV_W-1:0]           div_q;

  logic [SW-1:0]              center;
  logic [CMP_W-1:0]           avg_e, cen_e, adc_e, span;
  logic                       above;
  logic [SW-1:0]              mag;
  logic                       no_span;
  logic                       in_dead;
  logic [jac_pkg::PROD_W-1:0] prod;
  logic [jac_pkg::FS_W-1:0]   scaled;
  logic [jac_pkg::DIR_W-1:0]  mag8;

  assign job_ok   = q_rdata[SUM_W+1];
  assign job_axis = q_rdata[SUM_W];
  assign job_sum  = q_rdata[SUM_W-1:0];
  assign avg_prod = AVP_W'(job_sum) * AVP_W'(RCP_M);
  assign job_avg  = avg_prod[RCP_SH +: SW];

  assign center  = axis_r ? cfg.center_y : cfg.center_x;
  assign avg_e   = CMP_W'(avg_r);
  assign cen_e   = CMP_W'(center);
  assign adc_e   = CMP_W'(ADC_MAX);
  assign above   = (avg_e >= cen_e);
  assign mag     = above ? (avg_r - center) : (center - avg_r);
  assign span    = above ? (adc_e - cen_e) : cen_e;
  assign no_span = above ? (adc_e <= cen_e) : (cen_e == '0);
  assign in_dead = (mag < cfg.dead_zone);
  assign prod    = jac_pkg::PROD_W'(mag) * jac_pkg::PROD_W'(cfg.full_scale);
  assign div_dvd = prod;
  assign div_dvs = span;

  assign scaled = (div_q > DIV_W'(cfg.full_scale)) ? cfg.full_scale
                                                   : div_q[jac_pkg::FS_W-1:0];
  assign mag8   = {1'b0, scaled};

  jac_div #(
    .DVD_W (DIV_W),
    .DVS_W (CMP_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    avg_nxt   = avg_r;
    dir_nxt   = dir_r;
    ok_nxt    = ok_r;
    neg_nxt   = neg_r;
    ov_nxt    = ov_r && !out_tready;
    load_out  = 1'b0;
    q_pop     = 1'b0;
    div_start = 1'b0;
    case (state_r)
      jac_pkg::BK_IDLE: begin
        if (!q_status.empty) begin
          q_pop    = 1'b1;
          axis_nxt = job_axis;
          if (job_ok) begin
            avg_nxt   = job_avg;
            ok_nxt    = 1'b1;
            state_nxt = jac_pkg::BK_PREP;
          end else begin
            avg_nxt   = job_axis ? cfg.center_y : cfg.center_x;
            dir_nxt   = '0;
            ok_nxt    = 1'b0;
            state_nxt = jac_pkg::BK_FIN;
          end
        end
      end
      jac_pkg::BK_PREP: begin
        if (no_span || in_dead) begin
          dir_nxt   = '0;
          state_nxt = jac_pkg::BK_FIN;
        end else begin
          div_start = 1'b1;
          neg_nxt   = !above;
          state_nxt = jac_pkg::BK_SCALE;
        end
      end
      jac_pkg::BK_SCALE: begin
        if (div_done) begin
          dir_nxt   = neg_r ? (~mag8 + 1'b1) : mag8;
          state_nxt = jac_pkg::BK_FIN;
        end
      end
      jac_pkg::BK_FIN: begin
        if (!ov_r || out_tready) begin
          load_out  = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = jac_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = jac_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jac_pkg::BK_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    axis_r <= axis_nxt;
    avg_r  <= avg_nxt;
    dir_r  <= dir_nxt;
    ok_r   <= ok_nxt;
    neg_r  <= neg_nxt;
    if (load_out) begin
      out_axis_r <= axis_r;
      out_raw_r  <= avg_r;
      out_dir_r  <= dir_r;
      out_ok_r   <= ok_r;
    end
  end

  assign out_tvalid = ov_r;
  assign out_axis   = out_axis_r;
  assign out_raw    = out_raw_r;
  assign out_dir    = out_dir_r;
  assign out_ok     = out_ok_r;

endmodule

FILE: rtl/joystick_axis_conditioner.sv
// joystick axis conditioner top level: config registers, front, job queue, back
// depends on jac_pkg, jac_front, jac_fifo, jac_back and assert_macros.svh
// front takes one sample transaction per cycle while the job queue has room
// a scaled read goes through back states IDLE, PREP, SCALE (serial divider) and FIN before out_tvalid;
// a dead zone read skips SCALE, a failed sample goes from IDLE straight to FIN
// reset: config registers to their defaults, running sum and queue cleared, no result
`include "assert_macros.svh"

module joystick_axis_conditioner #(
  parameter int SAMPLES_PER_READ = jac_pkg::SAMPLES_PER_READ_DEF,
  parameter int ADC_MAX          = jac_pkg::ADC_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [11:0] sample, [15:12] zero
  input  logic [jac_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] axis, [1] sample_ok
  input  logic [jac_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [11:0] raw_average, [19:12] direction, [23:20] zero
  output logic [jac_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] out_axis, [1] adc_ok
  output logic [jac_pkg::OUT_TUSER_W-1:0] out_tuser,
  input  logic                            cfg_wr_en,
  input  logic [jac_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [jac_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int SUM_W = jac_pkg::SAMPLE_W + $clog2(SAMPLES_PER_READ);
  localparam int PAD_W = jac_pkg::OUT_TDATA_W - jac_pkg::SAMPLE_W - jac_pkg::DIR_W;

  jac_pkg::cfg_t      cfg_r, cfg_nxt;
  jac_pkg::q_status_t q_st;

  logic                         q_push;
  logic                         q_pop;
  logic [SUM_W+1:0]             q_wdata;
  logic [SUM_W+1:0]             q_rdata;
  logic                         res_axis;
  logic                         res_ok;
  logic [jac_pkg::SAMPLE_W-1:0] res_raw;
  logic [jac_pkg::DIR_W-1:0]    res_dir;
  logic [jac_pkg::DIR_W-1:0]    fs8;
  logic                         dir_in_range;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (jac_pkg::cfg_idx_t'(cfg_addr))
        jac_pkg::CFG_CENTER_X:   cfg_nxt.center_x   = cfg_wdata[jac_pkg::SAMPLE_W-1:0];
        jac_pkg::CFG_CENTER_Y:   cfg_nxt.center_y   = cfg_wdata[jac_pkg::SAMPLE_W-1:0];
        jac_pkg::CFG_DEAD_ZONE:  cfg_nxt.dead_zone  = cfg_wdata[jac_pkg::SAMPLE_W-1:0];
        jac_pkg::CFG_FULL_SCALE: cfg_nxt.full_scale = cfg_wdata[jac_pkg::FS_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x   <= jac_pkg::CENTER_RST;
      cfg_r.center_y   <= jac_pkg::CENTER_RST;
      cfg_r.dead_zone  <= jac_pkg::DEAD_ZONE_RST;
      cfg_r.full_scale <= jac_pkg::FULL_SCALE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  jac_front #(
    .SAMPLES_PER_READ (SAMPLES_PER_READ),
    .SUM_W            (SUM_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_sample    (in_tdata[jac_pkg::SAMPLE_W-1:0]),
    .in_axis      (in_tuser[0]),
    .in_sample_ok (in_tuser[1]),
    .q_status     (q_st),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  jac_fifo #(
    .WIDTH (SUM_W + 2),
    .DEPTH (jac_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_st)
  );

  jac_back #(
    .SAMPLES_PER_READ (SAMPLES_PER_READ),
    .ADC_MAX          (ADC_MAX),
    .SUM_W            (SUM_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_status   (q_st),
    .q_pop      (q_pop),
    .q_rdata    (q_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_axis   (res_axis),
    .out_raw    (res_raw),
    .out_dir    (res_dir),
    .out_ok     (res_ok)
  );

  assign out_tdata = {{PAD_W{1'b0}}, res_dir, res_raw};
  assign out_tuser = {res_ok, res_axis};
  assign fs8       = {1'b0, cfg_r.full_scale};
  assign dir_in_range = ($signed(res_dir) <= $signed(fs8)) &&
                        ($signed(res_dir) >= -$signed(fs8));

  `ASSERT_NEVER(a_queue_overflow, clk, rst_n, q_push && q_st.full)
  `ASSERT_NEVER(a_queue_underflow, clk, rst_n, q_pop && q_st.empty)
  `ASSERT_PROP(a_fail_dir_zero, clk, rst_n, out_tvalid && !res_ok |-> res_dir == '0)
  `ASSERT_PROP(a_dir_bound, clk, rst_n, out_tvalid |-> dir_in_range)

endmodule

FILE: dv/tb_joystick_axis_conditioner.sv
// self-checking testbench for joystick_axis_conditioner: directed table, then random reads
// predicts each random reading from its own copy of the calibration and sum state,
// takes directed expectations from the table, compares in order; depends on jac_pkg and the conditioner rtl
module tb_joystick_axis_conditioner;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = 100;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 140;
  localparam int READ_LEN    = jac_pkg::SAMPLES_PER_READ_DEF;
  localparam int FULL_RANGE  = jac_pkg::ADC_MAX_DEF;
  localparam int SAMPLE_W    = jac_pkg::SAMPLE_W;
  localparam int FS_W        = jac_pkg::FS_W;
  localparam int DIR_W       = jac_pkg::DIR_W;
  localparam int IN_TDATA_W  = jac_pkg::IN_TDATA_W;
  localparam int IN_TUSER_W  = jac_pkg::IN_TUSER_W;
  localparam int OUT_TDATA_W = jac_pkg::OUT_TDATA_W;
  localparam int OUT_TUSER_W = jac_pkg::OUT_TUSER_W;
  localparam int CFG_DATA_W  = jac_pkg::CFG_DATA_W;

  typedef struct packed {
    logic                axis;
    logic [SAMPLE_W-1:0] level;
    logic [DIR_W-1:0]    deflection;
    logic                conv_ok;
  } reading_t;

  typedef struct packed {
    logic                axis;
    logic [SAMPLE_W-1:0] sample;
    logic                conv_ok;
    logic                typed;
    reading_t            want;
  } row_t;

  localparam int NROWS = 25;
  localparam row_t STIM_TABLE [NROWS] = '{
    '{1'b0, 12'hABC, 1'b0, 1'b1, '{1'b0, 12'd2047, 8'd0, 1'b0}},
    '{1'b1, 12'd0,   1'b0, 1'b1, '{1'b1, 12'd2047, 8'd0, 1'b0}},
    '{1'b0, 12'd4095, 1'b1, 1'b0, '0},
    '{1'b0, 12'd4095, 1'b1, 1'b0, '0},
    '{1'b0, 12'd4095, 1'b1, 1'b0, '0},
    '{1'b0, 12'd4095, 1'b1, 1'b1, '{1'b0, 12'd4095, 8'd100, 1'b1}},
    '{1'b1, 12'd0,   1'b1, 1'b0, '0},
    '{1'b1, 12'd0,   1'b1, 1'b0, '0},
    '{1'b1, 12'd0,   1'b1, 1'b0, '0},
    '{1'b1, 12'd0,   1'b1, 1'b1, '{1'b1, 12'd0, 8'h9C, 1'b1}},
    '{1'b1, 12'd2047, 1'b1, 1'b0, '0},
    '{1'b0, 12'd2048, 1'b1, 1'b0, '0},
    '{1'b1, 12'd2047, 1'b1, 1'b0, '0},
    '{1'b0, 12'd2046, 1'b1, 1'b0, '0},
    '{1'b0, 12'd1000, 1'b1, 1'b0, '0},
    '{1'b1, 12'd3000, 1'b1, 1'b0, '0},
    '{1'b1, 12'd555,  1'b0, 1'b1, '{1'b1, 12'd2047, 8'd0, 1'b0}},
    '{1'b0, 12'd2347, 1'b1, 1'b0, '0},
    '{1'b0, 12'd2347, 1'b1, 1'b0, '0},
    '{1'b0, 12'd2347, 1'b1, 1'b0, '0},
    '{1'b0, 12'd2347, 1'b1, 1'b0, '0},
    '{1'b0, 12'd2346, 1'b1, 1'b0, '0},
    '{1'b0, 12'd2346, 1'b1, 1'b0, '0},
    '{1'b0, 12'd2346, 1'b1, 1'b0, '0},
    '{1'b0, 12'd2346, 1'b1, 1'b0, '0}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_wr_en;
  jac_pkg::cfg_idx_t      cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  joystick_axis_conditioner DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  logic [SAMPLE_W-1:0] cal_center_x;
  logic [SAMPLE_W-1:0] cal_center_y;
  logic [SAMPLE_W-1:0] cal_dead_zone;
  logic [FS_W-1:0]     cal_full_scale;
  int unsigned         acc_sum;
  int unsigned         acc_count;

  reading_t pending_readings[$];
  int       mismatches;
  int       samples_sent;
  int       readings_seen;
  int       failed_seen;
  int       settings_used;
  int       cycle_count;
  bit       idling_on;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [DIR_W-1:0] scale_deflection(int unsigned level,
                                                        int unsigned center);
    int unsigned mag;
    int unsigned span;
    int unsigned q;
    bit          neg;
    if (level >= center) begin
      neg = 1'b0;
      mag = level - center;
      if (center >= FULL_RANGE) return '0;
      span = FULL_RANGE - center;
    end else begin
      neg = 1'b1;
      mag = center - level;
      span = center;
    end
    if (mag < cal_dead_zone || span == 0) return '0;
    q = (mag * cal_full_scale) / span;
    if (q > cal_full_scale) q = cal_full_scale;
    return neg ? DIR_W'(-int'(q)) : DIR_W'(q);
  endfunction

  function automatic bit condition_sample(logic axis, logic [SAMPLE_W-1:0] sample,
                                          logic conv_ok, output reading_t res);
    int unsigned center;
    int unsigned avg;
    center = axis ? cal_center_y : cal_center_x;
    res = '0;
    res.axis = axis;
    if (!conv_ok) begin
      acc_sum = 0;
      acc_count = 0;
      res.level = SAMPLE_W'(center);
      return 1'b1;
    end
    acc_sum += sample;
    acc_count++;
    if (acc_count < READ_LEN) return 1'b0;
    avg = acc_sum / READ_LEN;
    acc_sum = 0;
    acc_count = 0;
    res.level = SAMPLE_W'(avg);
    res.deflection = scale_deflection(avg, center);
    res.conv_ok = 1'b1;
    return 1'b1;
  endfunction

  task automatic send_sample(logic axis, logic [SAMPLE_W-1:0] sample, logic conv_ok,
                             bit typed, reading_t want);
    reading_t res;
    bit       produced;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(sample);
    in_tuser  <= {conv_ok, axis};
    do @(posedge clk); while (!in_tready);
    samples_sent++;
    produced = condition_sample(axis, sample, conv_ok, res);
    if (typed) pending_readings.push_back(want);
    else if (produced) pending_readings.push_back(res);
  endtask

  task automatic drain_and_settle();
    in_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cal(jac_pkg::cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      jac_pkg::CFG_CENTER_X:   cal_center_x   = value;
      jac_pkg::CFG_CENTER_Y:   cal_center_y   = value;
      jac_pkg::CFG_DEAD_ZONE:  cal_dead_zone  = value;
      jac_pkg::CFG_FULL_SCALE: cal_full_scale = FS_W'(value);
      default: ;
    endcase
  endtask

  function automatic int clamp_level(int v);
    return v < 0 ? 0 : (v > FULL_RANGE ? FULL_RANGE : v);
  endfunction

  task automatic send_read();
    logic axis;
    logic ax;
    int   target;
    int   spread;
    int   center;
    int   k;
    axis = 1'($urandom_range(0, 1));
    center = axis ? cal_center_y : cal_center_x;
    case ($urandom_range(0, 6))
      0: target = 0;
      1: target = FULL_RANGE;
      2, 3: target = center + ($urandom_range(0, 1) ? 1 : -1)
                     * (int'(cal_dead_zone) + $urandom_range(0, 4) - 2);
      4: target = center + $urandom_range(0, 40) - 20;
      default: target = $urandom_range(0, FULL_RANGE);
    endcase
    spread = ($urandom_range(0, 3) == 0) ? 200 : 3;
    for (k = 0; k < READ_LEN; k++) begin
      ax = ($urandom_range(0, 7) == 0) ? 1'($urandom_range(0, 1)) : axis;
      send_sample(ax, SAMPLE_W'(clamp_level(target + $urandom_range(0, 2 * spread) - spread)),
                  1'($urandom_range(0, 15) != 0), 1'b0, '0);
    end
  endtask

  initial begin
    out_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (idling_on && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    reading_t got;
    reading_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser[0], out_tdata[11:0], out_tdata[19:12], out_tuser[1]};
      readings_seen++;
      if (!got.conv_ok) failed_seen++;
      if (pending_readings.size() == 0) begin
        mismatches++;
        $display("%0t unexpected reading: actual %h", $time, got);
      end else begin
        exp_r = pending_readings.pop_front();
        if (got.axis !== exp_r.axis) begin
          mismatches++;
          $display("%0t axis mismatch: expected %0d actual %0d", $time, exp_r.axis, got.axis);
        end
        if (got.level !== exp_r.level) begin
          mismatches++;
          $display("%0t raw_average mismatch: expected %0d actual %0d",
                   $time, exp_r.level, got.level);
        end
        if (got.deflection !== exp_r.deflection) begin
          mismatches++;
          $display("%0t direction mismatch: expected %0d actual %0d", $time,
                   $signed(exp_r.deflection), $signed(got.deflection));
        end
        if (got.conv_ok !== exp_r.conv_ok) begin
          mismatches++;
          $display("%0t adc_ok mismatch: expected %0d actual %0d",
                   $time, exp_r.conv_ok, got.conv_ok);
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d readings outstanding",
             cycle_count, pending_readings.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int phase;
    int base;
    int r;
    mismatches    = 0;
    samples_sent  = 0;
    readings_seen = 0;
    failed_seen   = 0;
    settings_used = 1;
    idling_on     = 1'b1;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_wr_en <= 1'b0;
    cfg_addr  <= jac_pkg::CFG_CENTER_X;
    cfg_wdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    cal_center_x   = jac_pkg::CENTER_RST;
    cal_center_y   = jac_pkg::CENTER_RST;
    cal_dead_zone  = jac_pkg::DEAD_ZONE_RST;
    cal_full_scale = jac_pkg::FULL_SCALE_RST;
    acc_sum   = 0;
    acc_count = 0;
    @(posedge clk);

    for (r = 0; r < NROWS; r++)
      send_sample(STIM_TABLE[r].axis, STIM_TABLE[r].sample, STIM_TABLE[r].conv_ok,
                  STIM_TABLE[r].typed, STIM_TABLE[r].want);

    for (phase = 0; phase < PHASES; phase++) begin
      drain_and_settle();
      case (phase)
        0: begin
          write_cal(jac_pkg::CFG_CENTER_X, 12'd0);
          write_cal(jac_pkg::CFG_CENTER_Y, 12'd4095);
          write_cal(jac_pkg::CFG_DEAD_ZONE, 12'd0);
          write_cal(jac_pkg::CFG_FULL_SCALE, 12'd127);
        end
        1: begin
          write_cal(jac_pkg::CFG_CENTER_X, 12'd4095);
          write_cal(jac_pkg::CFG_CENTER_Y, 12'd0);
          write_cal(jac_pkg::CFG_DEAD_ZONE, 12'd4095);
          write_cal(jac_pkg::CFG_FULL_SCALE, 12'd1);
        end
        2: begin
          write_cal(jac_pkg::CFG_CENTER_X, 12'd2048);
          write_cal(jac_pkg::CFG_CENTER_Y, 12'd2047);
          write_cal(jac_pkg::CFG_DEAD_ZONE, 12'd1);
          write_cal(jac_pkg::CFG_FULL_SCALE, 12'd64);
        end
        default: begin
          write_cal(jac_pkg::CFG_CENTER_X, CFG_DATA_W'($urandom_range(0, FULL_RANGE)));
          write_cal(jac_pkg::CFG_CENTER_Y, CFG_DATA_W'($urandom_range(0, FULL_RANGE)));
          write_cal(jac_pkg::CFG_DEAD_ZONE, CFG_DATA_W'(($urandom_range(0, 7) == 0)
                                   ? $urandom_range(0, FULL_RANGE) : $urandom_range(0, 600)));
          write_cal(jac_pkg::CFG_FULL_SCALE, CFG_DATA_W'($urandom_range(1, 127)));
        end
      endcase
      cfg_wr_en <= 1'b0;
      settings_used++;
      idling_on = (phase != PHASES - 1) && (phase % 3 != 2);
      base = samples_sent;
      while (samples_sent - base < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0)
          send_sample(1'($urandom_range(0, 1)), SAMPLE_W'($urandom_range(0, FULL_RANGE)),
                      1'($urandom_range(0, 1)), 1'b0, '0);
        else
          send_read();
      end
    end

    drain_and_settle();
    $display("sent %0d samples under %0d calibration settings", samples_sent, settings_used);
    $display("checked %0d readings, %0d of them conversion failures",
             readings_seen, failed_seen);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
